@@ rtl/four_byte_alu_branch_executor_macros.svh @@
// assertion helpers used by the executor rtl file
`ifndef FOUR_BYTE_ALU_BRANCH_EXECUTOR_MACROS_SVH
`define FOUR_BYTE_ALU_BRANCH_EXECUTOR_MACROS_SVH

// same-cycle implication
`define FBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbx same-cycle check failed");

// next-cycle implication
`define FBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbx next-cycle check failed");

`endif

@@ rtl/fbx_pkg.sv @@
package fbx_pkg;

  // opcode flag bits
  localparam int unsigned IMM_A_BIT = 7;
  localparam int unsigned IMM_B_BIT = 6;
  localparam int unsigned IMM_D_BIT = 5;

  // operation codes (low six opcode bits)
  typedef enum logic [5:0] {
    OP_ADD = 6'd0,
    OP_SUB = 6'd1,
    OP_AND = 6'd2,
    OP_OR  = 6'd3,
    OP_NOT = 6'd4,
    OP_XOR = 6'd5,
    OP_EQ  = 6'd32,
    OP_NEQ = 6'd33,
    OP_LT  = 6'd34,
    OP_LE  = 6'd35,
    OP_GT  = 6'd36,
    OP_GE  = 6'd37
  } op_code_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SRC    = 3'd1,
    ST_BAD_DEST   = 3'd2,
    ST_BAD_OP     = 3'd3,
    ST_NEG_TARGET = 3'd4,
    ST_PC_OVF     = 3'd5,
    ST_STOPPED    = 3'd6
  } status_t;

  // register index of the input port / output register
  localparam logic [7:0] PORT_IDX = 8'd7;

  // program counter step and last address that can still advance
  localparam logic [31:0] PC_STEP = 32'd4;
  localparam logic [31:0] PC_MAX  = 32'hFFFF_FFFB;

endpackage

@@ rtl/four_byte_alu_branch_executor.sv @@
// Executes one four-byte ALU or compare-branch instruction per transaction and
// returns the new program counter, output register, branch flag and status.
// Throughput is one transaction per clock unless a result stall holds it.
// Input acceptance captures the instruction and reads the register file (two
// write-first copies with registered read data) into the execute stage inputs;
// advance then runs the ALU/compare, commits state and loads the result register.
// A result stall holds the execute stage and reaches in_stall in the same cycle.
// Any error sets a sticky stop; afterwards every transaction reports status 6.
module four_byte_alu_branch_executor #(
  parameter int NUM_REGS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_opcode,
  input  logic signed [7:0]  in_src_a_byte,
  input  logic signed [7:0]  in_src_b_byte,
  input  logic signed [7:0]  in_dest_byte,
  input  logic signed [31:0] in_in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_next_pc,
  output logic signed [31:0] out_out_value,
  output logic               out_taken,
  output logic [2:0]         out_status
);

`include "four_byte_alu_branch_executor_macros.svh"

  localparam int         RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [7:0] NREG8  = 8'(NUM_REGS);

  // handshake
  logic s1_vld_r;
  logic out_vld_r;
  logic in_acc;
  logic advance;

  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  // architectural state
  logic [31:0]         pc_r;
  logic [31:0]         out_reg_r;
  logic                stopped_r;
  logic [NUM_REGS-1:0] rf_vld_r;
  logic [31:0]         rf_ab [NUM_REGS];
  logic [31:0]         rf_d [NUM_REGS];

  // execute stage input register
  logic [7:0]  op_r;
  logic [7:0]  a_byte_r;
  logic [7:0]  b_byte_r;
  logic [7:0]  d_byte_r;
  logic [31:0] port_r;
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;
  logic [31:0] rd_d_r;

  // register file write from the execute stage
  logic              rf_we;
  logic [RIDX_W-1:0] rf_widx;
  logic [31:0]       alu_res;

  // read addresses taken straight from the input ports
  logic              hit_a;
  logic              hit_b;
  logic              hit_d;
  logic [RIDX_W-1:0] ridx_a;
  logic [RIDX_W-1:0] ridx_b;
  logic [RIDX_W-1:0] ridx_d;

  always_comb begin
    hit_a  = $unsigned(in_src_a_byte) < NREG8;
    hit_b  = $unsigned(in_src_b_byte) < NREG8;
    hit_d  = $unsigned(in_dest_byte) < NREG8;
    ridx_a = hit_a ? in_src_a_byte[RIDX_W-1:0] : '0;
    ridx_b = hit_b ? in_src_b_byte[RIDX_W-1:0] : '0;
    ridx_d = hit_d ? in_dest_byte[RIDX_W-1:0] : '0;
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_opcode;
      a_byte_r <= in_src_a_byte;
      b_byte_r <= in_src_b_byte;
      d_byte_r <= in_dest_byte;
      port_r   <= in_in_value;
    end
  end

  // entry valid bits, cleared at reset so unwritten entries read zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_widx] <= 1'b1;
    end
  end

  // source copy of the register file, write-first registered reads
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_ab[rf_widx] <= alu_res;
    end
    if (in_acc) begin
      if (rf_we && rf_widx == ridx_a) begin
        rd_a_r <= alu_res;
      end else if (!rf_vld_r[ridx_a]) begin
        rd_a_r <= '0;
      end else begin
        rd_a_r <= rf_ab[ridx_a];
      end
      if (rf_we && rf_widx == ridx_b) begin
        rd_b_r <= alu_res;
      end else if (!rf_vld_r[ridx_b]) begin
        rd_b_r <= '0;
      end else begin
        rd_b_r <= rf_ab[ridx_b];
      end
    end
  end

  // destination copy of the register file
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_d[rf_widx] <= alu_res;
    end
    if (in_acc) begin
      if (rf_we && rf_widx == ridx_d) begin
        rd_d_r <= alu_res;
      end else if (!rf_vld_r[ridx_d]) begin
        rd_d_r <= '0;
      end else begin
        rd_d_r <= rf_d[ridx_d];
      end
    end
  end

  // operand decode
  logic        imm_a;
  logic        imm_b;
  logic        imm_d;
  logic [5:0]  code;
  logic        a_ok;
  logic        b_ok;
  logic        d_ok;
  logic        d_is_reg;
  logic        d_is_out;
  logic [31:0] val_a;
  logic [31:0] val_b;
  logic [31:0] val_d;

  always_comb begin
    imm_a    = op_r[fbx_pkg::IMM_A_BIT];
    imm_b    = op_r[fbx_pkg::IMM_B_BIT];
    imm_d    = op_r[fbx_pkg::IMM_D_BIT];
    code     = op_r[5:0];
    a_ok     = imm_a || a_byte_r < NREG8 || a_byte_r == fbx_pkg::PORT_IDX;
    b_ok     = imm_b || b_byte_r < NREG8 || b_byte_r == fbx_pkg::PORT_IDX;
    d_is_reg = !imm_d && d_byte_r < NREG8;
    d_is_out = !imm_d && !d_is_reg && d_byte_r == fbx_pkg::PORT_IDX;
    d_ok     = imm_d || d_is_reg || d_is_out;
    if (imm_a) begin
      val_a = {{24{a_byte_r[7]}}, a_byte_r};
    end else if (a_byte_r < NREG8) begin
      val_a = rd_a_r;
    end else begin
      val_a = port_r;
    end
    if (imm_b) begin
      val_b = {{24{b_byte_r[7]}}, b_byte_r};
    end else if (b_byte_r < NREG8) begin
      val_b = rd_b_r;
    end else begin
      val_b = port_r;
    end
    if (imm_d) begin
      val_d = {{24{d_byte_r[7]}}, d_byte_r};
    end else if (d_is_reg) begin
      val_d = rd_d_r;
    end else begin
      val_d = out_reg_r;
    end
  end

  // alu and compare
  logic is_alu;
  logic op_ok;
  logic cond;

  always_comb begin
    alu_res = '0;
    is_alu  = 1'b0;
    op_ok   = 1'b1;
    cond    = 1'b0;
    case (code)
      fbx_pkg::OP_ADD: begin alu_res = val_a + val_b; is_alu = 1'b1; end
      fbx_pkg::OP_SUB: begin alu_res = val_a - val_b; is_alu = 1'b1; end
      fbx_pkg::OP_AND: begin alu_res = val_a & val_b; is_alu = 1'b1; end
      fbx_pkg::OP_OR:  begin alu_res = val_a | val_b; is_alu = 1'b1; end
      fbx_pkg::OP_NOT: begin alu_res = ~val_a;        is_alu = 1'b1; end
      fbx_pkg::OP_XOR: begin alu_res = val_a ^ val_b; is_alu = 1'b1; end
      fbx_pkg::OP_EQ:  cond = (val_a == val_b);
      fbx_pkg::OP_NEQ: cond = (val_a != val_b);
      fbx_pkg::OP_LT:  cond = ($signed(val_a) < $signed(val_b));
      fbx_pkg::OP_LE:  cond = !($signed(val_b) < $signed(val_a));
      fbx_pkg::OP_GT:  cond = ($signed(val_b) < $signed(val_a));
      fbx_pkg::OP_GE:  cond = !($signed(val_a) < $signed(val_b));
      default:         op_ok = 1'b0;
    endcase
  end

  // status, commit and next state
  logic              pre_ok;
  logic              out_we;
  fbx_pkg::status_t  status;
  logic [31:0]       pc_nxt;
  logic [31:0]       out_reg_nxt;

  always_comb begin
    pre_ok  = !stopped_r && a_ok && b_ok && d_ok && op_ok;
    rf_we   = advance && pre_ok && is_alu && d_is_reg;
    out_we  = pre_ok && is_alu && d_is_out;
    rf_widx = d_byte_r[RIDX_W-1:0];
    pc_nxt  = pc_r;
    if (stopped_r) begin
      status = fbx_pkg::ST_STOPPED;
    end else if (!a_ok || !b_ok) begin
      status = fbx_pkg::ST_BAD_SRC;
    end else if (!d_ok) begin
      status = fbx_pkg::ST_BAD_DEST;
    end else if (!op_ok) begin
      status = fbx_pkg::ST_BAD_OP;
    end else if (cond && val_d[31]) begin
      status = fbx_pkg::ST_NEG_TARGET;
    end else if (cond) begin
      status = fbx_pkg::ST_OK;
      pc_nxt = val_d;
    end else if (pc_r > fbx_pkg::PC_MAX) begin
      status = fbx_pkg::ST_PC_OVF;
    end else begin
      status = fbx_pkg::ST_OK;
      pc_nxt = pc_r + fbx_pkg::PC_STEP;
    end
    out_reg_nxt = out_we ? alu_res : out_reg_r;
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      out_reg_r <= '0;
      stopped_r <= 1'b0;
    end else if (advance) begin
      pc_r      <= pc_nxt;
      out_reg_r <= out_reg_nxt;
      stopped_r <= stopped_r || status != fbx_pkg::ST_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_next_pc   <= pc_nxt;
      out_out_value <= out_reg_nxt;
      out_taken     <= status == fbx_pkg::ST_OK && cond;
      out_status    <= status;
    end
  end

  assign out_valid = out_vld_r;

  // checks
  `FBX_ASSERT_NXT(a_stop_sticky, clk, rst_n, stopped_r, stopped_r)
  `FBX_ASSERT_IMP(a_no_write_stopped, clk, rst_n, rf_we, !stopped_r && advance)
  `FBX_ASSERT_NXT(a_pc_frozen, clk, rst_n, advance && stopped_r, pc_r == $past(pc_r))
  `FBX_ASSERT_IMP(a_taken_ok, clk, rst_n, out_vld_r && out_taken,
                  out_status == fbx_pkg::ST_OK)

endmodule
